[rtl/udp_checksum_port_demux_core_assert.svh]
// Assertion macros for the RTL of the checksum and port demux core.
// Each check is sampled on the rising edge of clk and is off while rst_n is low.
`ifndef UDP_CHECKSUM_PORT_DEMUX_CORE_ASSERT_SVH
`define UDP_CHECKSUM_PORT_DEMUX_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

`define UDPC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("udpc assertion failed");

`define UDPC_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("udpc forbidden condition seen");

`else

`define UDPC_ASSERT(lbl, prop)

`define UDPC_ASSERT_NEVER(lbl, cond)

`endif

`endif

[rtl/udpc_pkg.sv]
package udpc_pkg;

  localparam int TABLE_DEPTH      = 8;
  localparam int MAX_PACKET_BYTES = 1500;
  localparam int IP_HEADER_BYTES  = 20;
  localparam int UDP_HEADER_BYTES = 8;
  localparam int SRC_IP_START     = 12;
  localparam logic [15:0] PROTO_UDP = 16'h0011;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int POS_W = $clog2(MAX_PACKET_BYTES + 2);

  localparam logic [2:0] STS_DELIVERED  = 3'd0;
  localparam logic [2:0] STS_BAD_CSUM   = 3'd1;
  localparam logic [2:0] STS_NO_HANDLER = 3'd2;
  localparam logic [2:0] STS_REGISTERED = 3'd3;
  localparam logic [2:0] STS_TABLE_FULL = 3'd4;

  // Lookup token that walks the cell chain, one cell per cycle.
  typedef struct packed {
    logic             active;
    logic [15:0]      key;
    logic             found;
    logic [IDX_W-1:0] idx;
  } search_tok_t;

  // Packet summary produced on the last byte of a packet.
  typedef struct packed {
    logic        bad;
    logic [15:0] port;
    logic [15:0] csum;
  } pkt_end_t;

  // One's-complement 16-bit add with end-around carry.
  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'b0, s[16]};
  endfunction

endpackage

[rtl/udpc_cell.sv]
module udpc_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [udpc_pkg::IDX_W-1:0]   my_idx,
  input  logic                         wr_en,
  input  logic [15:0]                  wr_port,
  input  udpc_pkg::search_tok_t        tok_in,
  output udpc_pkg::search_tok_t        tok_out
);

  logic                  valid_r;
  logic [15:0]           entry_r;
  udpc_pkg::search_tok_t tok_r;
  udpc_pkg::search_tok_t tok_nxt;

  // The first matching cell marks the token; later cells leave it alone.
  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.active && !tok_in.found && valid_r && (entry_r == tok_in.key)) begin
      tok_nxt.found = 1'b1;
      tok_nxt.idx   = my_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r   <= '0;
    end else begin
      if (wr_en) begin
        valid_r <= 1'b1;
      end
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_r <= wr_port;
    end
  end

  assign tok_out = tok_r;

endmodule

[rtl/udpc_csum.sv]
module udpc_csum (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  byte_en,
  input  logic [7:0]            byte_in,
  input  logic                  last_in,
  output udpc_pkg::pkt_end_t    end_info
);

  localparam int PW = udpc_pkg::POS_W;

  logic [PW-1:0] pos_r, pos_nxt;
  logic [15:0]   sum_r, sum_nxt;
  logic [7:0]    held_r, held_nxt;
  logic [15:0]   len_r, len_nxt;
  logic [15:0]   rcv_r, rcv_nxt;
  logic [15:0]   port_r, port_nxt;

  always_comb begin
    logic [PW-1:0] off;
    logic [15:0]   word;
    logic [15:0]   sum1;
    logic          taking;
    logic          add2;
    pos_nxt  = pos_r;
    sum_nxt  = sum_r;
    held_nxt = held_r;
    len_nxt  = len_r;
    rcv_nxt  = rcv_r;
    port_nxt = port_r;
    off      = pos_r - PW'(udpc_pkg::IP_HEADER_BYTES);
    word     = pos_r[0] ? {8'h00, byte_in} : {byte_in, 8'h00};
    taking   = (pos_r < PW'(udpc_pkg::MAX_PACKET_BYTES));
    sum1     = sum_r;
    add2     = 1'b0;
    if (taking) begin
      if (pos_r == '0) begin
        sum_nxt  = udpc_pkg::PROTO_UDP;
        held_nxt = '0;
        len_nxt  = '0;
        rcv_nxt  = '0;
        port_nxt = '0;
      end else if (pos_r >= PW'(udpc_pkg::SRC_IP_START) &&
                   pos_r < PW'(udpc_pkg::IP_HEADER_BYTES)) begin
        sum_nxt = udpc_pkg::ones_add(sum_r, word);
      end else if (pos_r >= PW'(udpc_pkg::IP_HEADER_BYTES)) begin
        if (off == PW'(2) || off == PW'(4) || off == PW'(6)) begin
          held_nxt = byte_in;
        end else if (off == PW'(3)) begin
          port_nxt = {held_r, byte_in};
        end else if (off == PW'(5)) begin
          len_nxt = {held_r, byte_in};
        end else if (off == PW'(7)) begin
          rcv_nxt = {held_r, byte_in};
        end
        // The length word joins the pseudo-header as it arrives.
        if (off == PW'(5)) begin
          sum1 = udpc_pkg::ones_add(sum_r, {held_r, byte_in});
        end
        // The checksum field counts as zero; the header is always summed.
        add2 = !(off == PW'(6) || off == PW'(7)) &&
               ((off < PW'(udpc_pkg::UDP_HEADER_BYTES)) || (16'(off) < len_nxt));
        sum_nxt = add2 ? udpc_pkg::ones_add(sum1, word) : sum1;
      end
      pos_nxt = pos_r + PW'(1);
    end else begin
      pos_nxt = PW'(udpc_pkg::MAX_PACKET_BYTES + 1);
    end
    if (last_in) begin
      pos_nxt = '0;
    end
    end_info.csum = ~sum_nxt;
    end_info.port = port_nxt;
    end_info.bad  = (pos_r < PW'(udpc_pkg::IP_HEADER_BYTES + udpc_pkg::UDP_HEADER_BYTES - 1)) ||
                    !taking || (~sum_nxt != rcv_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      sum_r  <= '0;
      held_r <= '0;
      len_r  <= '0;
      rcv_r  <= '0;
      port_r <= '0;
    end else if (byte_en) begin
      pos_r  <= pos_nxt;
      sum_r  <= sum_nxt;
      held_r <= held_nxt;
      len_r  <= len_nxt;
      rcv_r  <= rcv_nxt;
      port_r <= port_nxt;
    end
  end

endmodule

[rtl/udp_checksum_port_demux_core.sv]
// UDP checksum checker with a port table, for one IPv4 packet at a time.
// Input channel (in_valid / in_stall): command 0 carries one packet byte,
// starting at the IP header, with in_last_byte on the final byte; command 1
// registers in_port_value in the port table.
// Result channel (out_valid / out_stall): one transfer per register command
// and one per packet end; a packet byte that is not the last gives none.
// Packet bytes that are not last are taken one per cycle while in_stall
// is low. A last byte with a bad checksum yields its result in the cycle
// after the transfer. A register command or a last byte with a good
// checksum sends a lookup token down the row of TABLE_DEPTH cells, one
// cell per cycle; the input stalls until the token leaves the last cell.
// The result register holds a result while out_stall is high; the input
// then stalls as well until that result is taken.
// Reset (rst_n low, synchronous) empties the table and the packet state.
module udp_checksum_port_demux_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [7:0]  in_packet_byte,
  input  logic        in_last_byte,
  input  logic [15:0] in_port_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [2:0]  out_handler_index,
  output logic [15:0] out_destination_port,
  output logic [15:0] out_computed_checksum
);

  `include "udp_checksum_port_demux_core_assert.svh"

  localparam int D  = udpc_pkg::TABLE_DEPTH;
  localparam int CW = udpc_pkg::CNT_W;
  localparam int IW = udpc_pkg::IDX_W;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_SEARCH = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  logic                  accept;
  logic                  launch;
  logic                  byte_en;
  logic                  bad_load;
  logic                  tail_done;
  logic                  ins_en;
  logic                  out_load;
  udpc_pkg::pkt_end_t    end_info;
  udpc_pkg::search_tok_t chain [D+1];
  udpc_pkg::search_tok_t tail;
  logic [D-1:0]          cell_wr;

  logic [CW-1:0] count_r;
  logic          reg_cmd_r;
  logic [15:0]   pkt_port_r;
  logic [15:0]   pkt_cs_r;
  logic          out_valid_r;
  logic [2:0]    out_status_r, status_nxt;
  logic [2:0]    out_idx_r, idx_nxt;
  logic [15:0]   out_port_r, port_nxt;
  logic [15:0]   out_cs_r, cs_nxt;

  assign in_stall = (state_r == ST_SEARCH) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;
  assign byte_en  = accept && !in_command;
  assign bad_load = byte_en && in_last_byte && end_info.bad;
  assign launch   = accept && (in_command || (in_last_byte && !end_info.bad));

  udpc_csum u_csum (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_en  (byte_en),
    .byte_in  (in_packet_byte),
    .last_in  (in_last_byte),
    .end_info (end_info)
  );

  assign chain[0] = '{active: launch,
                      key:    (in_command ? in_port_value : end_info.port),
                      found:  1'b0,
                      idx:    '0};

  for (genvar i = 0; i < D; i++) begin : g_cell
    assign cell_wr[i] = ins_en && (count_r == CW'(i));
    udpc_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .my_idx  (IW'(i)),
      .wr_en   (cell_wr[i]),
      .wr_port (tail.key),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1])
    );
  end

  assign tail      = chain[D];
  assign tail_done = tail.active;
  assign ins_en    = tail_done && reg_cmd_r && !tail.found && (count_r < CW'(D));
  assign out_load  = bad_load || tail_done;

  always_comb begin
    status_nxt = udpc_pkg::STS_BAD_CSUM;
    idx_nxt    = '0;
    port_nxt   = end_info.port;
    cs_nxt     = end_info.csum;
    if (tail_done) begin
      if (reg_cmd_r) begin
        port_nxt = '0;
        cs_nxt   = '0;
        if (tail.found) begin
          status_nxt = udpc_pkg::STS_REGISTERED;
          idx_nxt    = 3'(tail.idx);
        end else if (count_r < CW'(D)) begin
          status_nxt = udpc_pkg::STS_REGISTERED;
          idx_nxt    = 3'(count_r);
        end else begin
          status_nxt = udpc_pkg::STS_TABLE_FULL;
        end
      end else begin
        port_nxt = pkt_port_r;
        cs_nxt   = pkt_cs_r;
        if (tail.found) begin
          status_nxt = udpc_pkg::STS_DELIVERED;
          idx_nxt    = 3'(tail.idx);
        end else begin
          status_nxt = udpc_pkg::STS_NO_HANDLER;
        end
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (launch) begin
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (tail_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ins_en) begin
        count_r <= count_r + CW'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (launch) begin
      reg_cmd_r  <= in_command;
      pkt_port_r <= end_info.port;
      pkt_cs_r   <= end_info.csum;
    end
    if (out_load) begin
      out_status_r <= status_nxt;
      out_idx_r    <= idx_nxt;
      out_port_r   <= port_nxt;
      out_cs_r     <= cs_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_status            = out_status_r;
  assign out_handler_index     = out_idx_r;
  assign out_destination_port  = out_port_r;
  assign out_computed_checksum = out_cs_r;

  // A launched token always reaches the end of the row, through all TABLE_DEPTH cells.
  `UDPC_ASSERT(a_search_len, launch |-> ##D tail_done)
  `UDPC_ASSERT(a_tail_in_search, tail_done |-> (state_r == ST_SEARCH))
  `UDPC_ASSERT_NEVER(a_load_over_full, out_load && out_valid_r && out_stall)
  `UDPC_ASSERT_NEVER(a_count_bound, count_r > CW'(D))
  `UDPC_ASSERT(a_insert_counts, ins_en |=> (count_r == $past(count_r) + CW'(1)))

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  localparam int   PW           = udpc_pkg::POS_W;
  localparam logic CMD_PACKET   = 1'b0;
  localparam logic CMD_REGISTER = 1'b1;

  typedef enum int {LEN_EXACT, LEN_SHORT, LEN_LONG, LEN_WILD} len_mode_t;
  typedef enum int {SUM_GOOD, SUM_FLIPPED, SUM_ZERO} sum_mode_t;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  pbyte;
    logic        last;
    logic [15:0] port;
  } rx_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  idx;
    logic [15:0] dport;
    logic [15:0] csum;
  } demux_result_t;

  // Running state of the packet being received.
  typedef struct packed {
    logic [PW-1:0] pos;
    logic [16:0]   sum;
    logic [7:0]    held;
    logic [15:0]   ulen;
    logic [15:0]   rx_csum;
    logic [15:0]   dport;
  } rx_state_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_command = 1'b0;
  logic [7:0]  in_packet_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic [15:0] in_port_value = 16'h0000;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [2:0]  out_handler_index;
  logic [15:0] out_destination_port;
  logic [15:0] out_computed_checksum;

  rx_item_t      pending_q[$];
  demux_result_t expected_q[$];
  logic [15:0]   known_ports[$];

  logic [15:0]   port_tab[udpc_pkg::TABLE_DEPTH];
  int            tab_count = 0;
  rx_state_t     rx = '0;

  int            sent_count = 0;
  int            mismatches = 0;
  logic          hold_off = 1'b0;
  rx_item_t      staged_item;
  demux_result_t want;

  udp_checksum_port_demux_core dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_command            (in_command),
    .in_packet_byte        (in_packet_byte),
    .in_last_byte          (in_last_byte),
    .in_port_value         (in_port_value),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_status            (out_status),
    .out_handler_index     (out_handler_index),
    .out_destination_port  (out_destination_port),
    .out_computed_checksum (out_computed_checksum)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #10_000_000;
    $display("tb_top: errors");
    $finish;
  end

  function automatic logic [16:0] fold_add(input logic [16:0] acc, input logic [15:0] w);
    logic [16:0] s;
    s = acc + {1'b0, w};
    return {1'b0, s[15:0]} + {16'b0, s[16]};
  endfunction

  // One packet byte into the checksum state. Bytes past the size limit only
  // pin the position one above the limit.
  function automatic void absorb_byte(inout rx_state_t st, input logic [7:0] b);
    int          p;
    int          off;
    logic [15:0] word;
    p = int'(st.pos);
    if (p >= udpc_pkg::MAX_PACKET_BYTES) begin
      st.pos = PW'(udpc_pkg::MAX_PACKET_BYTES + 1);
      return;
    end
    st.pos = PW'(p + 1);
    word = p[0] ? {8'h00, b} : {b, 8'h00};
    if (p == 0) begin
      st.sum = {1'b0, udpc_pkg::PROTO_UDP};
      st.held = 8'h00;
      st.ulen = 16'h0000;
      st.rx_csum = 16'h0000;
      st.dport = 16'h0000;
    end
    if (p >= udpc_pkg::SRC_IP_START && p < udpc_pkg::IP_HEADER_BYTES) begin
      st.sum = fold_add(st.sum, word);
      return;
    end
    if (p < udpc_pkg::IP_HEADER_BYTES) return;
    off = p - udpc_pkg::IP_HEADER_BYTES;
    case (off)
      2, 4, 6: st.held = b;
      3: st.dport = {st.held, b};
      5: begin
        st.ulen = {st.held, b};
        st.sum = fold_add(st.sum, st.ulen);
      end
      7: st.rx_csum = {st.held, b};
      default: ;
    endcase
    // The checksum field itself is read as zero.
    if (off == 6 || off == 7) return;
    if (off < udpc_pkg::UDP_HEADER_BYTES || off < int'(st.ulen))
      st.sum = fold_add(st.sum, word);
  endfunction

  function automatic void predict_transfer(input rx_item_t it);
    demux_result_t r;
    int            p;
    int            i;
    logic [15:0]   cs;
    bit            hit;
    r = '0;
    hit = 1'b0;
    if (it.cmd == CMD_REGISTER) begin
      for (i = 0; i < tab_count; i++) begin
        if (!hit && port_tab[i] == it.port) begin
          hit = 1'b1;
          r.status = udpc_pkg::STS_REGISTERED;
          r.idx = i[2:0];
        end
      end
      if (!hit) begin
        if (tab_count < udpc_pkg::TABLE_DEPTH) begin
          port_tab[tab_count] = it.port;
          r.status = udpc_pkg::STS_REGISTERED;
          r.idx = tab_count[2:0];
          tab_count++;
        end else begin
          r.status = udpc_pkg::STS_TABLE_FULL;
        end
      end
      expected_q.push_back(r);
      return;
    end
    p = int'(rx.pos);
    absorb_byte(rx, it.pbyte);
    if (!it.last) return;
    rx.pos = '0;
    cs = ~rx.sum[15:0];
    r.dport = rx.dport;
    r.csum = cs;
    if (p + 1 < udpc_pkg::IP_HEADER_BYTES + udpc_pkg::UDP_HEADER_BYTES ||
        p >= udpc_pkg::MAX_PACKET_BYTES || cs != rx.rx_csum) begin
      r.status = udpc_pkg::STS_BAD_CSUM;
    end else begin
      r.status = udpc_pkg::STS_NO_HANDLER;
      for (i = 0; i < tab_count; i++) begin
        if (!hit && port_tab[i] == rx.dport) begin
          hit = 1'b1;
          r.status = udpc_pkg::STS_DELIVERED;
          r.idx = i[2:0];
        end
      end
    end
    expected_q.push_back(r);
  endfunction

  function automatic void report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t mismatch: %s", $time, msg);
  endfunction

  function automatic rx_item_t register_item(input logic [15:0] port);
    rx_item_t it;
    it.cmd = CMD_REGISTER;
    it.pbyte = 8'($urandom_range(255));
    it.last = 1'($urandom_range(1));
    it.port = port;
    known_ports.push_back(port);
    return it;
  endfunction

  function automatic logic [15:0] pick_reg_port();
    int k;
    k = $urandom_range(99);
    if (known_ports.size() != 0 && k < 35)
      return known_ports[$urandom_range(known_ports.size() - 1)];
    if (k < 39) return 16'h0000;
    if (k < 43) return 16'hFFFF;
    return 16'($urandom_range(65535));
  endfunction

  function automatic logic [15:0] pick_dport();
    int k;
    k = $urandom_range(99);
    if (known_ports.size() != 0 && k < 65)
      return known_ports[$urandom_range(known_ports.size() - 1)];
    if (k < 68) return 16'h0000;
    if (k < 71) return 16'hFFFF;
    return 16'($urandom_range(65535));
  endfunction

  // Builds one packet and queues its bytes. A nonzero send_len cuts the
  // packet short; extra appends bytes beyond the payload.
  task automatic add_packet(input int paylen, input logic [15:0] dport,
                            input len_mode_t lmode, input sum_mode_t smode,
                            input int send_len, input int extra, input bit mix);
    logic [7:0]  pkt[$];
    rx_state_t   gs;
    logic [15:0] ulen;
    logic [15:0] word;
    rx_item_t    it;
    int          n;
    int          i;
    case (lmode)
      LEN_EXACT: ulen = 16'(udpc_pkg::UDP_HEADER_BYTES + paylen);
      LEN_SHORT: ulen = 16'($urandom_range(udpc_pkg::UDP_HEADER_BYTES - 1 + paylen));
      LEN_LONG:  ulen = 16'(udpc_pkg::UDP_HEADER_BYTES + paylen + $urandom_range(1, 40));
      default:   ulen = 16'($urandom_range(65535));
    endcase
    for (i = 0; i < udpc_pkg::IP_HEADER_BYTES + 2; i++) begin
      pkt.push_back(8'($urandom_range(255)));
    end
    pkt.push_back(dport[15:8]);
    pkt.push_back(dport[7:0]);
    pkt.push_back(ulen[15:8]);
    pkt.push_back(ulen[7:0]);
    pkt.push_back(8'h00);
    pkt.push_back(8'h00);
    for (i = 0; i < paylen + extra; i++) pkt.push_back(8'($urandom_range(255)));
    gs = '0;
    for (i = 0; i < pkt.size(); i++) absorb_byte(gs, pkt[i]);
    word = ~gs.sum[15:0];
    if (smode == SUM_FLIPPED) word = word ^ 16'($urandom_range(1, 65535));
    else if (smode == SUM_ZERO) word = 16'h0000;
    pkt[udpc_pkg::IP_HEADER_BYTES + 6] = word[15:8];
    pkt[udpc_pkg::IP_HEADER_BYTES + 7] = word[7:0];
    n = (send_len != 0) ? send_len : pkt.size();
    for (i = 0; i < n; i++) begin
      it.cmd = CMD_PACKET;
      it.pbyte = pkt[i];
      it.last = (i == n - 1);
      it.port = 16'($urandom_range(65535));
      pending_q.push_back(it);
      if (mix && i != n - 1 && $urandom_range(199) == 0)
        pending_q.push_back(register_item(pick_reg_port()));
    end
  endtask

  function automatic int sender_gap_pct();
    case ((sent_count / 150) % 4)
      1: return 55;
      3: return 6;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_stall_pct();
    case ((sent_count / 150) % 4)
      2: return 55;
      3: return 6;
      default: return 0;
    endcase
  endfunction

  initial begin : stimulus
    int        pick;
    int        paylen;
    len_mode_t lmode;
    sum_mode_t smode;

    // Smallest good packet to a known port, with a duplicate registration
    // landing in the middle of it, then a one-byte fragment.
    pending_q.push_back(register_item(16'h0000));
    pending_q.push_back(register_item(16'hFFFF));
    add_packet(0, 16'hFFFF, LEN_EXACT, SUM_GOOD, 0, 0, 1'b0);
    pending_q.insert(pending_q.size() - 12, register_item(16'h0000));
    add_packet(0, 16'h1234, LEN_EXACT, SUM_GOOD, 1, 0, 1'b0);

    while (pending_q.size() < 1650) begin
      pick = $urandom_range(99);
      if (pick < 22) begin
        pending_q.push_back(register_item(pick_reg_port()));
      end else if (pick < 30) begin
        add_packet(0, pick_dport(), LEN_EXACT, SUM_GOOD, $urandom_range(1, 27), 0, 1'b1);
      end else begin
        paylen = ($urandom_range(9) == 0) ? $urandom_range(25, 200) : $urandom_range(0, 24);
        pick = $urandom_range(99);
        if (pick < 80) lmode = LEN_EXACT;
        else if (pick < 88) lmode = LEN_SHORT;
        else if (pick < 95) lmode = LEN_LONG;
        else lmode = LEN_WILD;
        pick = $urandom_range(99);
        if (pick < 82) smode = SUM_GOOD;
        else if (pick < 94) smode = SUM_FLIPPED;
        else smode = SUM_ZERO;
        add_packet(paylen, pick_dport(), lmode, smode, 0, 0, 1'b1);
      end
    end

    while (pending_q.size() != 0 || in_valid) @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // Long receiver hold-off while the sender keeps offering, so the result
  // register fills and the input side backs up.
  initial begin
    wait (sent_count >= 400);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (200) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_q.size() != 0 && (hold_off || $urandom_range(99) >= sender_gap_pct())) begin
        staged_item = pending_q.pop_front();
        in_valid <= 1'b1;
        in_command <= staged_item.cmd;
        in_packet_byte <= staged_item.pbyte;
        in_last_byte <= staged_item.last;
        in_port_value <= staged_item.port;
        sent_count <= sent_count + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= hold_off || ($urandom_range(99) < receiver_stall_pct());
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        predict_transfer({in_command, in_packet_byte, in_last_byte, in_port_value});
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("unexpected transfer: status %0d index %0d port %h sum %h",
                                    out_status, out_handler_index, out_destination_port,
                                    out_computed_checksum));
        end else begin
          want = expected_q.pop_front();
          if (want.status != out_status || want.idx != out_handler_index ||
              want.dport != out_destination_port || want.csum != out_computed_checksum) begin
            report_mismatch($sformatf(
              "expected status %0d index %0d port %h sum %h, got %0d %0d %h %h",
              want.status, want.idx, want.dport, want.csum, out_status,
              out_handler_index, out_destination_port, out_computed_checksum));
          end
        end
      end
    end
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/udpc_pkg.sv
rtl/udpc_cell.sv
rtl/udpc_csum.sv
rtl/udp_checksum_port_demux_core.sv
bench/tb_top.sv
